FILE: rtl/running_moment_statistics_unit_assert.svh
// Assertion macros for the running moment statistics unit.
// Expects clk and arst_n in the scope of use.
`ifndef RUNNING_MOMENT_STATISTICS_UNIT_ASSERT_SVH
`define RUNNING_MOMENT_STATISTICS_UNIT_ASSERT_SVH

// condition must never hold
`define RMS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// consequent holds in the same cycle
`define RMS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the following cycle
`define RMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rms_pkg.sv
// Shared types, constants and the finalize step program of the moment unit.
// No dependencies.
`default_nettype none
package rms_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam logic [15:0] COUNT_MAX = 16'd65535;
	localparam int WIDE_BITS = 192;
	localparam int PW_BITS = 48;
	localparam int MUL_BITS = 64;
	localparam int SQRT_STEPS = 48;

	localparam logic [2:0] SEL_SAMPLE_SD = 3'd0;
	localparam logic [2:0] SEL_POP_SD = 3'd1;
	localparam logic [2:0] SEL_SAMPLE_VAR = 3'd2;
	localparam logic [2:0] SEL_POP_VAR = 3'd3;
	localparam logic [2:0] SEL_SKEW = 3'd4;
	localparam logic [2:0] SEL_KURT = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_UNDEF = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;

	localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

	typedef logic [WIDE_BITS-1:0] wide_t;
	typedef logic [3:0][WIDE_BITS-1:0] tfile_t;

	typedef enum logic [2:0] {
		ACC_IDLE, ACC_SQ, ACC_CU, ACC_QU, ACC_AD
	} acc_state_t;

	typedef enum logic [3:0] {
		E_IDLE, E_CHECK, E_STEP, E_MUL, E_SCALE, E_DIV, E_ROUND, E_SQRT, E_FINISH
	} eng_state_t;

	typedef enum logic [1:0] {
		OP_DONE, OP_MUL, OP_MAC, OP_MSU
	} op_t;

	typedef enum logic [3:0] {
		SRC_S1, SRC_S2, SRC_S3, SRC_S4, SRC_N, SRC_NM1,
		SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_K, SRC_ONE
	} src_t;

	typedef struct packed {
		op_t op;
		logic [1:0] dst;
		src_t a;
		src_t b;
		logic [3:0] k;
	} step_t;

	typedef struct packed {
		logic [15:0] count;
		logic signed [27:0] s1;
		logic [39:0] s2;
		logic signed [51:0] s3;
		logic [60:0] s4;
		logic ovf;
	} sums_t;

	typedef struct packed {
		logic valid;
		logic [63:0] value;
		logic [1:0] status;
	} res_t;

	function automatic step_t mk(input op_t op, input logic [1:0] dst, input src_t a,
		input src_t b, input logic [3:0] k);
		step_t s;
		s.op = op;
		s.dst = dst;
		s.a = a;
		s.b = b;
		s.k = k;
		return s;
	endfunction

	// variance and deviation: T1 = V; skew: T2 = numerator;
	// kurtosis: T2 = numerator, T1 = n*n - 3n + 3
	function automatic step_t prog_step(input logic [2:0] sel, input logic [4:0] pc);
		step_t s;
		s = mk(OP_DONE, 2'd0, SRC_ONE, SRC_ONE, 4'd0);
		if (sel == SEL_SKEW) begin
			case (pc)
				5'd0: s = mk(OP_MUL, 2'd0, SRC_N, SRC_N, 4'd0);
				5'd1: s = mk(OP_MUL, 2'd2, SRC_S3, SRC_T0, 4'd0);
				5'd2: s = mk(OP_MUL, 2'd0, SRC_S2, SRC_S1, 4'd0);
				5'd3: s = mk(OP_MUL, 2'd3, SRC_N, SRC_K, 4'd3);
				5'd4: s = mk(OP_MSU, 2'd2, SRC_T0, SRC_T3, 4'd0);
				5'd5: s = mk(OP_MUL, 2'd0, SRC_S1, SRC_S1, 4'd0);
				5'd6: s = mk(OP_MUL, 2'd0, SRC_T0, SRC_S1, 4'd0);
				5'd7: s = mk(OP_MAC, 2'd2, SRC_T0, SRC_K, 4'd2);
				default: s = mk(OP_DONE, 2'd0, SRC_ONE, SRC_ONE, 4'd0);
			endcase
		end else if (sel == SEL_KURT) begin
			case (pc)
				5'd0: s = mk(OP_MUL, 2'd1, SRC_S2, SRC_N, 4'd0);
				5'd1: s = mk(OP_MSU, 2'd1, SRC_S1, SRC_S1, 4'd0);
				5'd2: s = mk(OP_MUL, 2'd0, SRC_N, SRC_N, 4'd0);
				5'd3: s = mk(OP_MUL, 2'd0, SRC_T0, SRC_N, 4'd0);
				5'd4: s = mk(OP_MUL, 2'd2, SRC_S4, SRC_T0, 4'd0);
				5'd5: s = mk(OP_MUL, 2'd0, SRC_N, SRC_N, 4'd0);
				5'd6: s = mk(OP_MUL, 2'd0, SRC_T0, SRC_K, 4'd4);
				5'd7: s = mk(OP_MUL, 2'd3, SRC_S3, SRC_S1, 4'd0);
				5'd8: s = mk(OP_MSU, 2'd2, SRC_T3, SRC_T0, 4'd0);
				5'd9: s = mk(OP_MUL, 2'd0, SRC_S1, SRC_S1, 4'd0);
				5'd10: s = mk(OP_MUL, 2'd0, SRC_S2, SRC_T0, 4'd0);
				5'd11: s = mk(OP_MUL, 2'd3, SRC_N, SRC_K, 4'd6);
				5'd12: s = mk(OP_MAC, 2'd2, SRC_T0, SRC_T3, 4'd0);
				5'd13: s = mk(OP_MUL, 2'd0, SRC_S1, SRC_S1, 4'd0);
				5'd14: s = mk(OP_MUL, 2'd0, SRC_T0, SRC_T0, 4'd0);
				5'd15: s = mk(OP_MSU, 2'd2, SRC_T0, SRC_K, 4'd3);
				5'd16: s = mk(OP_MUL, 2'd0, SRC_NM1, SRC_NM1, 4'd0);
				5'd17: s = mk(OP_MUL, 2'd0, SRC_T0, SRC_N, 4'd0);
				5'd18: s = mk(OP_MAC, 2'd0, SRC_N, SRC_K, 4'd6);
				5'd19: s = mk(OP_MSU, 2'd0, SRC_K, SRC_ONE, 4'd9);
				5'd20: s = mk(OP_MUL, 2'd2, SRC_T2, SRC_T0, 4'd0);
				5'd21: s = mk(OP_MUL, 2'd3, SRC_T1, SRC_T1, 4'd0);
				5'd22: s = mk(OP_MUL, 2'd0, SRC_N, SRC_K, 4'd6);
				5'd23: s = mk(OP_MSU, 2'd0, SRC_K, SRC_ONE, 4'd9);
				5'd24: s = mk(OP_MUL, 2'd0, SRC_T0, SRC_N, 4'd0);
				5'd25: s = mk(OP_MAC, 2'd2, SRC_T3, SRC_T0, 4'd0);
				5'd26: s = mk(OP_MUL, 2'd1, SRC_N, SRC_N, 4'd0);
				5'd27: s = mk(OP_MSU, 2'd1, SRC_N, SRC_K, 4'd3);
				5'd28: s = mk(OP_MAC, 2'd1, SRC_K, SRC_ONE, 4'd3);
				default: s = mk(OP_DONE, 2'd0, SRC_ONE, SRC_ONE, 4'd0);
			endcase
		end else begin
			case (pc)
				5'd0: s = mk(OP_MUL, 2'd1, SRC_S2, SRC_N, 4'd0);
				5'd1: s = mk(OP_MSU, 2'd1, SRC_S1, SRC_S1, 4'd0);
				default: s = mk(OP_DONE, 2'd0, SRC_ONE, SRC_ONE, 4'd0);
			endcase
		end
		return s;
	endfunction

	function automatic logic [2:0] div_count(input logic [2:0] sel);
		logic [2:0] c;
		case (sel)
			SEL_SKEW: c = 3'd3;
			SEL_KURT: c = 3'd6;
			default: c = 3'd2;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] divisor(input logic [2:0] sel, input logic [2:0] dk,
		input logic [15:0] n, input logic [31:0] dlast);
		logic [31:0] d;
		logic [31:0] n32;
		n32 = {16'd0, n};
		case (sel)
			SEL_POP_SD, SEL_POP_VAR: d = n32;
			SEL_SKEW: d = (dk == 3'd0) ? n32 : ((dk == 3'd1) ? n32 - 32'd1 : n32 - 32'd2);
			SEL_KURT: d = (dk == 3'd5) ? dlast : n32;
			default: d = (dk == 3'd0) ? n32 : n32 - 32'd1;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/running_moment_statistics_unit.sv
// Top level of the running moment statistics unit: handshakes, select register,
// result register. Depends on rms_pkg, rms_accum, rms_engine and the assert header.
//
// channel  | signals                                   | word
// input    | in_valid in_ready command sample          | accumulate or finalize
// output   | out_valid out_ready result_value status   | one statistic per finalize
// config   | psel penable pwrite paddr pwdata prdata   | stat_select at byte 0
//
// Accumulate: the word is taken, then the SQ, CU, QU and AD states use one
// multiplier to form the powers; ready stays low meanwhile.
// Finalize: the step program runs on shift-add multiply steps, then the divides
// follow, and for deviation a square root. Empty, overflowed or trivial cases go
// straight from the check to the result.
// Reset clears the sums and the select; a held result stalls only a finalize.
`default_nettype none
`include "running_moment_statistics_unit_assert.svh"
module running_moment_statistics_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic command,
	input wire logic signed [rms_pkg::SAMPLE_BITS-1:0] sample,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [63:0] result_value,
	output logic [1:0] status,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [2:0] stat_select_q;
	logic out_valid_q;
	logic [63:0] result_value_q;
	logic [1:0] status_q;
	logic in_acc, acc_start, eng_start;
	logic acc_busy, eng_busy, eng_clear;
	rms_pkg::sums_t sums;
	rms_pkg::res_t eng_res;

	assign in_ready = !acc_busy && !eng_busy;
	assign in_acc = in_valid && in_ready;
	assign acc_start = in_acc && !command;
	assign eng_start = in_acc && command;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {29'd0, stat_select_q};
	assign out_valid = out_valid_q;
	assign result_value = result_value_q;
	assign status = status_q;

	rms_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.start(acc_start),
		.sample(sample),
		.clear(eng_clear),
		.busy(acc_busy),
		.sums(sums)
	);

	rms_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(eng_start),
		.sel(stat_select_q),
		.sums(sums),
		.slot_free(!out_valid_q),
		.res(eng_res),
		.busy(eng_busy),
		.clear(eng_clear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_select_q <= rms_pkg::SEL_SAMPLE_SD;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && !paddr[2]) stat_select_q <= pwdata[2:0];
			if (eng_res.valid) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res.valid) begin
			result_value_q <= eng_res.value;
			status_q <= eng_res.status;
		end
	end

	`RMS_ASSERT_NEVER(a_one_owner, acc_busy && eng_busy, "accumulator and engine both busy")
	`RMS_ASSERT_IMP(a_slot_free, eng_res.valid, !out_valid_q, "result written over a held word")
	`RMS_ASSERT_NEXT(a_sums_clear, eng_res.valid, sums.count == 16'd0 && !sums.ovf, "sums not cleared")

endmodule
`default_nettype wire

FILE: rtl/rms_accum.sv
// Sample count and power-sum accumulator of the moment unit.
// Depends on rms_pkg; one shared 48x12 multiplier forms x^2, x^3, x^4 in turn.
`default_nettype none
module rms_accum (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [rms_pkg::SAMPLE_BITS-1:0] sample,
	input wire logic clear,
	output logic busy,
	output rms_pkg::sums_t sums
);

	rms_pkg::acc_state_t state_q, state_nx;
	rms_pkg::sums_t sums_q;
	logic signed [rms_pkg::SAMPLE_BITS-1:0] x_q;
	logic signed [rms_pkg::PW_BITS-1:0] pw_q;
	logic signed [rms_pkg::PW_BITS+rms_pkg::SAMPLE_BITS-1:0] prod;
	logic full;

	assign prod = pw_q * x_q;
	assign full = (sums_q.count == rms_pkg::COUNT_MAX);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rms_pkg::ACC_IDLE: if (start && !full) state_nx = rms_pkg::ACC_SQ;
			rms_pkg::ACC_SQ: state_nx = rms_pkg::ACC_CU;
			rms_pkg::ACC_CU: state_nx = rms_pkg::ACC_QU;
			rms_pkg::ACC_QU: state_nx = rms_pkg::ACC_AD;
			rms_pkg::ACC_AD: state_nx = rms_pkg::ACC_IDLE;
			default: state_nx = rms_pkg::ACC_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != rms_pkg::ACC_IDLE);
		sums = sums_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rms_pkg::ACC_IDLE;
			sums_q <= '0;
		end else begin
			state_q <= state_nx;
			if (clear) begin
				sums_q <= '0;
			end else begin
				case (state_q)
					rms_pkg::ACC_IDLE: begin
						if (start) begin
							if (full) begin
								sums_q.ovf <= 1'b1;
							end else begin
								sums_q.count <= sums_q.count + 16'd1;
								sums_q.s1 <= sums_q.s1 + 28'(sample);
							end
						end
					end
					rms_pkg::ACC_CU: sums_q.s2 <= sums_q.s2 + 40'(pw_q);
					rms_pkg::ACC_QU: sums_q.s3 <= sums_q.s3 + 52'(pw_q);
					rms_pkg::ACC_AD: sums_q.s4 <= sums_q.s4 + 61'(pw_q);
					default: sums_q <= sums_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rms_pkg::ACC_IDLE: begin
				x_q <= sample;
				pw_q <= rms_pkg::PW_BITS'(sample);
			end
			rms_pkg::ACC_SQ, rms_pkg::ACC_CU, rms_pkg::ACC_QU: pw_q <= prod[rms_pkg::PW_BITS-1:0];
			default: pw_q <= pw_q;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/rms_engine.sv
// Finalize engine: step sequencer over a shift-add multiply unit, a restoring
// divider and a digit-by-digit square root. Depends on rms_pkg.
`default_nettype none
module rms_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] sel,
	input wire rms_pkg::sums_t sums,
	input wire logic slot_free,
	output rms_pkg::res_t res,
	output logic busy,
	output logic clear
);

	localparam int W = rms_pkg::WIDE_BITS;

	rms_pkg::eng_state_t state_q, state_nx;
	logic [2:0] sel_q;
	logic [4:0] pc_q;
	logic [7:0] it_q;
	logic [2:0] dk_q;
	rms_pkg::tfile_t t_q;
	rms_pkg::wide_t mul_a_q, acc_q, m_q;
	logic [rms_pkg::MUL_BITS-1:0] mul_b_q;
	logic msu_q;
	logic [32:0] rem_q;
	logic [51:0] srem_q;
	logic [rms_pkg::SQRT_STEPS-1:0] root_q;
	logic [63:0] val_q;
	logic [1:0] stat_q;

	rms_pkg::step_t step;
	rms_pkg::wide_t opa, opb_w, acc_nx, num, magv, mr;
	logic [rms_pkg::MUL_BITS-1:0] opb;
	logic sub;
	logic spec_hit;
	logic [1:0] spec_status;
	logic is_root, last_div, mul_last, div_last, sqrt_last;
	logic [31:0] dv;
	logic [32:0] rem_sh, rem_nx;
	logic ge;
	logic [51:0] s_sh, trial;
	logic sge;
	logic [rms_pkg::SQRT_STEPS-1:0] root_nx;
	logic big;

	function automatic rms_pkg::wide_t opnd(input rms_pkg::src_t s, input rms_pkg::sums_t sm,
		input rms_pkg::tfile_t t, input logic [3:0] k);
		rms_pkg::wide_t v;
		case (s)
			rms_pkg::SRC_S1: v = {{(W-28){sm.s1[27]}}, sm.s1};
			rms_pkg::SRC_S2: v = W'(sm.s2);
			rms_pkg::SRC_S3: v = {{(W-52){sm.s3[51]}}, sm.s3};
			rms_pkg::SRC_S4: v = W'(sm.s4);
			rms_pkg::SRC_N: v = W'(sm.count);
			rms_pkg::SRC_NM1: v = W'(sm.count - 16'd1);
			rms_pkg::SRC_T0: v = t[0];
			rms_pkg::SRC_T1: v = t[1];
			rms_pkg::SRC_T2: v = t[2];
			rms_pkg::SRC_T3: v = t[3];
			rms_pkg::SRC_K: v = W'(k);
			rms_pkg::SRC_ONE: v = W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		step = rms_pkg::prog_step(sel_q, pc_q);
		opa = opnd(step.a, sums, t_q, step.k);
		opb_w = opnd(step.b, sums, t_q, step.k);
		opb = opb_w[rms_pkg::MUL_BITS-1:0];
		mul_last = (it_q == 8'(rms_pkg::MUL_BITS - 1));
		sub = msu_q ^ mul_last;
		if (mul_b_q[0]) acc_nx = sub ? acc_q - mul_a_q : acc_q + mul_a_q;
		else acc_nx = acc_q;

		is_root = (sel_q == rms_pkg::SEL_SAMPLE_SD) || (sel_q == rms_pkg::SEL_POP_SD);
		num = ((sel_q == rms_pkg::SEL_SKEW) || (sel_q == rms_pkg::SEL_KURT)) ? t_q[2] : t_q[1];
		magv = num[W-1] ? (~num + W'(1)) : num;

		dv = rms_pkg::divisor(sel_q, dk_q, sums.count, t_q[1][31:0]);
		last_div = (dk_q == rms_pkg::div_count(sel_q) - 3'd1);
		div_last = (it_q == 8'(W - 1));
		rem_sh = {rem_q[31:0], m_q[W-1]};
		ge = (rem_sh >= {1'b0, dv});
		rem_nx = ge ? rem_sh - {1'b0, dv} : rem_sh;

		sqrt_last = (it_q == 8'(rms_pkg::SQRT_STEPS - 1));
		s_sh = {srem_q[49:0], m_q[95:94]};
		trial = {2'b00, root_q, 2'b01};
		sge = (s_sh >= trial);
		root_nx = {root_q[rms_pkg::SQRT_STEPS-2:0], sge};

		mr = (m_q + W'(1)) >> 1;
		big = |mr[W-1:64];

		spec_hit = 1'b1;
		spec_status = rms_pkg::ST_OK;
		if (sums.ovf) spec_status = rms_pkg::ST_OVF;
		else if (sums.count == 16'd0) spec_status = rms_pkg::ST_EMPTY;
		else if (sel_q > rms_pkg::SEL_KURT) spec_status = rms_pkg::ST_UNDEF;
		else if (sums.count == 16'd1) spec_status = rms_pkg::ST_OK;
		else if ((sel_q == rms_pkg::SEL_SKEW) && (sums.count == 16'd2))
			spec_status = rms_pkg::ST_UNDEF;
		else spec_hit = 1'b0;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rms_pkg::E_IDLE: if (start) state_nx = rms_pkg::E_CHECK;
			rms_pkg::E_CHECK: state_nx = spec_hit ? rms_pkg::E_FINISH : rms_pkg::E_STEP;
			rms_pkg::E_STEP:
				state_nx = (step.op == rms_pkg::OP_DONE) ? rms_pkg::E_SCALE : rms_pkg::E_MUL;
			rms_pkg::E_MUL: if (mul_last) state_nx = rms_pkg::E_STEP;
			rms_pkg::E_SCALE: state_nx = rms_pkg::E_DIV;
			rms_pkg::E_DIV:
				if (div_last && last_div) state_nx = is_root ? rms_pkg::E_SQRT : rms_pkg::E_ROUND;
			rms_pkg::E_ROUND: state_nx = rms_pkg::E_FINISH;
			rms_pkg::E_SQRT: if (sqrt_last) state_nx = rms_pkg::E_FINISH;
			rms_pkg::E_FINISH: if (slot_free) state_nx = rms_pkg::E_IDLE;
			default: state_nx = rms_pkg::E_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != rms_pkg::E_IDLE);
		clear = (state_q == rms_pkg::E_FINISH) && slot_free;
		res.valid = clear;
		res.value = val_q;
		res.status = stat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rms_pkg::E_IDLE;
		else state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rms_pkg::E_IDLE: sel_q <= sel;
			rms_pkg::E_CHECK: begin
				val_q <= '0;
				stat_q <= spec_status;
				pc_q <= '0;
			end
			rms_pkg::E_STEP: begin
				mul_a_q <= opa;
				mul_b_q <= opb;
				acc_q <= (step.op == rms_pkg::OP_MUL) ? '0 : t_q[step.dst];
				msu_q <= (step.op == rms_pkg::OP_MSU);
				it_q <= '0;
			end
			rms_pkg::E_MUL: begin
				acc_q <= acc_nx;
				mul_a_q <= {mul_a_q[W-2:0], 1'b0};
				mul_b_q <= {1'b0, mul_b_q[rms_pkg::MUL_BITS-1:1]};
				it_q <= it_q + 8'd1;
				if (mul_last) begin
					t_q[step.dst] <= acc_nx;
					pc_q <= pc_q + 5'd1;
				end
			end
			rms_pkg::E_SCALE: begin
				m_q <= is_root ? (num << 48) : (magv << 25);
				rem_q <= '0;
				srem_q <= '0;
				root_q <= '0;
				it_q <= '0;
				dk_q <= '0;
			end
			rms_pkg::E_DIV: begin
				m_q <= {m_q[W-2:0], ge};
				if (div_last) begin
					it_q <= '0;
					rem_q <= '0;
					dk_q <= dk_q + 3'd1;
				end else begin
					rem_q <= rem_nx;
					it_q <= it_q + 8'd1;
				end
			end
			rms_pkg::E_ROUND: begin
				if (!magv[W-1] && !num[W-1]) begin
					if (big || mr[63]) begin
						val_q <= rms_pkg::VAL_MAX;
						stat_q <= rms_pkg::ST_OVF;
					end else begin
						val_q <= mr[63:0];
						stat_q <= rms_pkg::ST_OK;
					end
				end else begin
					if (big || (mr[63] && |mr[62:0])) begin
						val_q <= rms_pkg::VAL_MIN;
						stat_q <= rms_pkg::ST_OVF;
					end else begin
						val_q <= ~mr[63:0] + 64'd1;
						stat_q <= rms_pkg::ST_OK;
					end
				end
			end
			rms_pkg::E_SQRT: begin
				srem_q <= sge ? s_sh - trial : s_sh;
				root_q <= root_nx;
				m_q <= {m_q[W-3:0], 2'b00};
				it_q <= it_q + 8'd1;
				if (sqrt_last) begin
					val_q <= 64'(root_nx);
					stat_q <= rms_pkg::ST_OK;
				end
			end
			default: val_q <= val_q;
		endcase
	end

endmodule
`default_nettype wire
